// ----- src/kmer_pkg.sv -----
// Shared types, constants and functions for the k-mer count hash table.
package kmer_pkg;
	localparam int TABLE_SIZE_DEF = 4093;
	localparam int COVER_MAX_DEF = 63;
	localparam logic [11:0] MAX_FILL_RST = 12'd3069;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic {
		KIND_PUT    = 1'b0,
		KIND_SEARCH = 1'b1
	} kind_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] seq;
		logic [2:0]  left_base;
		logic [2:0]  right_base;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] slot;
		logic [23:0] left_covs;
		logic [23:0] right_covs;
		logic        single_mark;
		logic [11:0] entry_total;
	} rsp_t;

	// Queued item: request plus its home slot.
	typedef struct packed {
		req_t        req;
		logic [15:0] home;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_READ,
		BK_CHECK,
		BK_OUT
	} bk_state_t;

	function automatic logic [23:0] bump_counter(input logic [23:0] packed_c,
	                                             input logic [2:0] base,
	                                             input logic [5:0] cap);
		logic [23:0] r;
		r = packed_c;
		for (int i = 0; i < 4; i++) begin
			if (base == 3'(i) && r[i*6 +: 6] < cap)
				r[i*6 +: 6] = r[i*6 +: 6] + 6'd1;
		end
		return r;
	endfunction
endpackage

// ----- src/kmer_if.sv -----
// Valid/ready channel interface.
interface kmer_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/kmer_front.sv -----
// Front end: accepts items and folds the key down to its home slot.
module kmer_front #(
	parameter int TABLE_SIZE = kmer_pkg::TABLE_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	kmer_if.sink          in_ch,
	output logic          job_valid,
	input  logic          job_ready,
	output kmer_pkg::job_t job
);
	import kmer_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam logic [AW-1:0] FOLD_C = AW'((64'd1 << AW) - 64'(TABLE_SIZE));
	// 2**AW is congruent to FOLD_C: one fold per cycle until the key fits AW bits.
	logic          busy_q;
	logic          done_q;
	req_t          req_q;
	logic [63:0]   v_q;
	logic [63:0]   fold;
	logic          fits;
	logic [AW-1:0] home;

	assign fits = (v_q >> AW) == 64'd0;
	assign fold = (v_q >> AW) * 64'(FOLD_C) + 64'(v_q[AW-1:0]);
	assign home = (v_q[AW-1:0] >= AW'(TABLE_SIZE)) ?
	              v_q[AW-1:0] - AW'(TABLE_SIZE) : v_q[AW-1:0];

	assign in_ch.ready = !busy_q && !done_q;
	assign job_valid   = done_q;
	assign job.req     = req_q;
	assign job.home    = 16'(home);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && job_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			req_q <= in_ch.data;
			v_q   <= in_ch.data.seq;
		end else if (busy_q && !fits) begin
			v_q <= fold;
		end
	end

	a_home_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> fits && 32'(home) < TABLE_SIZE) else $error("home slot out of range");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("front busy and done");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !job_ready |=> done_q && $stable(v_q)) else $error("job dropped");
endmodule

// ----- src/kmer_queue.sv -----
// Two-entry queue between front and back.
module kmer_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  kmer_pkg::job_t in_job,
	output logic           out_valid,
	input  logic           out_ready,
	output kmer_pkg::job_t out_job
);
	import kmer_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_job   = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer mismatch");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 && !push |=> !out_valid) else $error("phantom item");
endmodule

// ----- src/kmer_back.sv -----
// Back end: probes the table memory, updates entries, registers the result.
module kmer_back #(
	parameter int TABLE_SIZE = kmer_pkg::TABLE_SIZE_DEF,
	parameter int COVER_MAX  = kmer_pkg::COVER_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [11:0]    max_fill,
	input  logic           job_valid,
	output logic           job_ready,
	input  kmer_pkg::job_t job,
	kmer_if.source         out_ch
);
	import kmer_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam logic [5:0] CAP = (COVER_MAX > 63) ? 6'd63 : 6'(COVER_MAX);

	typedef struct packed {
		logic        occ;
		logic [63:0] key;
		logic [23:0] lc;
		logic [23:0] rc;
		logic        single;
	} ent_t;

	ent_t      mem [TABLE_SIZE];
	ent_t      rd_q;
	bk_state_t st_q, st_d;
	req_t      req_q;
	logic [AW-1:0] pos_q, pos_d, clr_q, clr_d;
	logic [CW-1:0] n_q, n_d, cnt_q, cnt_d;
	logic      wr_en;
	logic [AW-1:0] wr_addr;
	ent_t      wr_data;
	rsp_t      rsp_q, rsp_d;
	logic      ov_q, ov_d;
	logic [AW-1:0] pos_nx;

	assign pos_nx = (pos_q == AW'(TABLE_SIZE - 1)) ? '0 : pos_q + AW'(1);
	assign out_ch.valid = ov_q;
	assign out_ch.data  = rsp_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[pos_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q  <= st_d;
			clr_q <= clr_d;
			cnt_q <= cnt_d;
			ov_q  <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		n_q   <= n_d;
		rsp_q <= rsp_d;
		if (job_valid && job_ready) req_q <= job.req;
	end

	always_comb begin
		st_d = st_q; pos_d = pos_q; clr_d = clr_q; n_d = n_q; cnt_d = cnt_q;
		rsp_d = rsp_q; ov_d = ov_q;
		wr_en = 1'b0; wr_addr = pos_q; wr_data = rd_q;
		job_ready = 1'b0;
		if (out_ch.ready) ov_d = 1'b0;
		unique case (st_q)
			BK_CLEAR: begin
				wr_en = 1'b1; wr_addr = clr_q; wr_data = '0;
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(TABLE_SIZE - 1)) st_d = BK_IDLE;
			end
			BK_IDLE: begin
				// next item only once the result register is free
				job_ready = !ov_q || out_ch.ready;
				if (job_valid && job_ready) begin
					pos_d = AW'(job.home);
					n_d   = '0;
					st_d  = BK_READ;
				end
			end
			BK_READ: st_d = BK_CHECK;
			BK_CHECK: begin
				rsp_d = '0;
				rsp_d.entry_total = 12'(cnt_q);
				if (!rd_q.occ) begin
					rsp_d.status = (req_q.kind == KIND_PUT) ? ST_FULL : ST_NOT_FOUND;
					if (req_q.kind == KIND_PUT && 13'(cnt_q) < {1'b0, max_fill}) begin
						wr_en = 1'b1;
						wr_data.occ = 1'b1;
						wr_data.key = req_q.seq;
						wr_data.lc  = bump_counter('0, req_q.left_base, CAP);
						wr_data.rc  = bump_counter('0, req_q.right_base, CAP);
						wr_data.single = 1'b1;
						cnt_d = cnt_q + CW'(1);
						rsp_d = '{ST_INSERTED, 12'(pos_q), wr_data.lc, wr_data.rc,
						           1'b1, 12'(cnt_d)};
					end
					st_d = BK_OUT;
				end else if (rd_q.key == req_q.seq) begin
					if (req_q.kind == KIND_PUT) begin
						wr_en = 1'b1;
						wr_data.lc = bump_counter(rd_q.lc, req_q.left_base, CAP);
						wr_data.rc = bump_counter(rd_q.rc, req_q.right_base, CAP);
						wr_data.single = 1'b0;
						rsp_d = '{ST_UPDATED, 12'(pos_q), wr_data.lc, wr_data.rc,
						           1'b0, 12'(cnt_q)};
					end else begin
						rsp_d = '{ST_FOUND, 12'(pos_q), rd_q.lc, rd_q.rc,
						           rd_q.single, 12'(cnt_q)};
					end
					st_d = BK_OUT;
				end else if (n_q == CW'(TABLE_SIZE - 1)) begin
					rsp_d.status = (req_q.kind == KIND_PUT) ? ST_FULL : ST_NOT_FOUND;
					st_d = BK_OUT;
				end else begin
					pos_d = pos_nx;
					n_d   = n_q + CW'(1);
					st_d  = BK_READ;
				end
			end
			BK_OUT: begin
				if (!ov_q || out_ch.ready) begin
					ov_d = 1'b1;
					st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_SIZE)) else $error("entry count overflow");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + CW'(1)) else $error("count jump");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ch.ready |=> ov_q && $stable(rsp_q)) else $error("result lost");
endmodule

// ----- src/kmer_count_hash_table.sv -----
// Top level of the k-mer count hash table.
// Usage:
//  in:  valid/ready channel carrying kind, seq, left_base, right_base.
//  out: valid/ready channel carrying status, slot, covers, single_mark and
//       entry_total; exactly one result item per input item, in order.
//  max_fill_we / max_fill_wdata write the fill limit while idle.
// Flow: the front folds the key to its home slot, one fold per cycle until
//  it fits the index width (at most 7 folds for a 64-bit key at the default
//  size), then hands it through a two-entry queue to the back. The back takes
//  the item, then per probed slot reads the memory, compares and writes
//  back, and then posts the result. The front takes a new item only once it
//  has handed the last to the queue, the back only once it has posted the
//  last result; the slower side sets the rate.
// Reset: all control state clears; the back then sweeps the occupancy of
//  the table, one slot per cycle over all slots, taking no item meanwhile.
// Stall: a result held by the receiver keeps the back idle; the front and
//  queue keep accepting until the queue fills.
module kmer_count_hash_table #(
	parameter int TABLE_SIZE = kmer_pkg::TABLE_SIZE_DEF,
	parameter int COVER_MAX  = kmer_pkg::COVER_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_fill_we,
	input  logic [11:0] max_fill_wdata,
	kmer_if.sink        in,
	kmer_if.source      out
);
	import kmer_pkg::*;

	logic [11:0] max_fill_q;
	logic        fj_valid, fj_ready, qj_valid, qj_ready;
	job_t        fj, qj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_fill_q <= MAX_FILL_RST;
		else if (max_fill_we) max_fill_q <= max_fill_wdata;
	end

	kmer_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
		.clk, .arst_n, .in_ch(in),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	kmer_queue u_queue (
		.clk, .arst_n,
		.in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
		.out_valid(qj_valid), .out_ready(qj_ready), .out_job(qj)
	);

	kmer_back #(.TABLE_SIZE(TABLE_SIZE), .COVER_MAX(COVER_MAX)) u_back (
		.clk, .arst_n, .max_fill(max_fill_q),
		.job_valid(qj_valid), .job_ready(qj_ready), .job(qj), .out_ch(out)
	);
endmodule

// ----- test/tb_kmer_count_hash_table.sv -----
// Testbench for kmer_count_hash_table: random and directed puts and searches.
module tb_kmer_count_hash_table;
	import kmer_pkg::*;

	localparam int TBL = TABLE_SIZE_DEF;
	localparam logic [5:0] CAP = 6'd63;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic max_fill_we = 1'b0;
	logic [11:0] max_fill_wdata = '0;

	kmer_if #(.T(req_t)) req_ch ();
	kmer_if #(.T(rsp_t)) rsp_ch ();

	kmer_count_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.max_fill_we(max_fill_we),
		.max_fill_wdata(max_fill_wdata),
		.in(req_ch.sink),
		.out(rsp_ch.source)
	);

	always #10 clk = ~clk;

	// table model
	logic [63:0] key_tab [TBL];
	bit occ_tab [TBL];
	logic [23:0] lcov_tab [TBL];
	logic [23:0] rcov_tab [TBL];
	bit single_tab [TBL];
	int unsigned stored_cnt = 0;
	logic [11:0] fill_limit = MAX_FILL_RST;

	req_t pending_q[$];
	rsp_t expected_q[$];
	logic [63:0] known_keys[$];
	logic [63:0] hot_key;
	int errors = 0;
	bit calm_tx = 0;
	bit calm_rx = 0;

	function automatic logic [23:0] add_cov(logic [23:0] packed_c, logic [2:0] base);
		logic [23:0] r;
		logic [5:0] c;
		r = packed_c;
		if (base < 3'd4) begin
			c = r[base*6 +: 6];
			if (c < CAP)
				c = c + 6'd1;
			r[base*6 +: 6] = c;
		end
		return r;
	endfunction

	function automatic rsp_t lookup_or_insert(req_t r);
		int unsigned p;
		bit hit;
		rsp_t o;
		p = int'(r.seq % 64'(TBL));
		o = '0;
		o.status = (r.kind == KIND_PUT) ? ST_FULL : ST_NOT_FOUND;
		hit = 0;
		for (int n = 0; n < TBL; n++) begin
			if (!occ_tab[p]) begin
				if (r.kind == KIND_PUT && stored_cnt < fill_limit) begin
					occ_tab[p] = 1;
					key_tab[p] = r.seq;
					lcov_tab[p] = add_cov('0, r.left_base);
					rcov_tab[p] = add_cov('0, r.right_base);
					single_tab[p] = 1;
					stored_cnt++;
					o.status = ST_INSERTED;
					hit = 1;
				end
				break;
			end
			if (key_tab[p] == r.seq) begin
				if (r.kind == KIND_PUT) begin
					lcov_tab[p] = add_cov(lcov_tab[p], r.left_base);
					rcov_tab[p] = add_cov(rcov_tab[p], r.right_base);
					single_tab[p] = 0;
					o.status = ST_UPDATED;
				end else begin
					o.status = ST_FOUND;
				end
				hit = 1;
				break;
			end
			p = (p + 1 == TBL) ? 0 : p + 1;
		end
		if (hit) begin
			o.slot = 12'(p);
			o.left_covs = lcov_tab[p];
			o.right_covs = rcov_tab[p];
			o.single_mark = single_tab[p];
		end
		o.entry_total = 12'(stored_cnt);
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	// driver
	req_t cur_req;
	int tx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic v_next;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			tx_gap = 0;
		end else begin
			v_next = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				expected_q.push_back(lookup_or_insert(cur_req));
				v_next = 1'b0;
				tx_gap = calm_tx ? 0 : $urandom_range(0, 14);
			end
			if (!v_next) begin
				if (tx_gap > 0)
					tx_gap--;
				else if (pending_q.size() > 0) begin
					cur_req = pending_q.pop_front();
					req_ch.data <= cur_req;
					v_next = 1'b1;
				end
			end
			req_ch.valid <= v_next;
		end
	end

	// monitor
	int rx_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		rsp_t w;
		rsp_t g;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				g = rsp_ch.data;
				if (expected_q.size() == 0) begin
					report("unexpected item", 64'(g), 64'd0);
				end else begin
					w = expected_q.pop_front();
					if (g.status !== w.status)
						report("status", 64'(g.status), 64'(w.status));
					if (g.slot !== w.slot) report("slot", 64'(g.slot), 64'(w.slot));
					if (g.left_covs !== w.left_covs)
						report("left_covs", 64'(g.left_covs), 64'(w.left_covs));
					if (g.right_covs !== w.right_covs)
						report("right_covs", 64'(g.right_covs), 64'(w.right_covs));
					if (g.single_mark !== w.single_mark)
						report("single_mark", 64'(g.single_mark), 64'(w.single_mark));
					if (g.entry_total !== w.entry_total)
						report("entry_total", 64'(g.entry_total), 64'(w.entry_total));
				end
				rx_stall = calm_rx ? 0 : $urandom_range(0, 14);
			end
			if (rx_stall > 0) begin
				rx_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic req_t mk(logic k, logic [63:0] s, logic [2:0] lb, logic [2:0] rb);
		req_t r;
		r.kind = k;
		r.seq = s;
		r.left_base = lb;
		r.right_base = rb;
		return r;
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] same_home(int unsigned h);
		logic [63:0] m;
		m = {14'd0, 18'($urandom_range(0, 32'h3FFFF)), $urandom};
		return 64'(h) + m * 64'(TBL);
	endfunction

	function automatic req_t random_item();
		int sel;
		logic [63:0] k;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return mk(KIND_PUT, hot_key, 3'($urandom_range(0, 1)), 3'($urandom_range(2, 3)));
		if (sel < 45 && known_keys.size() > 0)
			return mk(KIND_PUT, known_keys[$urandom_range(0, known_keys.size() - 1)],
				3'($urandom), 3'($urandom));
		if (sel < 60) begin
			if ($urandom_range(0, 1) && known_keys.size() > 0)
				k = same_home(int'(known_keys[$urandom_range(0, known_keys.size() - 1)]
					% 64'(TBL)));
			else
				k = rand_key();
			known_keys.push_back(k);
			return mk(KIND_PUT, k, 3'($urandom), 3'($urandom));
		end
		if (sel < 85 && known_keys.size() > 0)
			return mk(KIND_SEARCH, known_keys[$urandom_range(0, known_keys.size() - 1)],
				3'($urandom), 3'($urandom));
		return mk(KIND_SEARCH, rand_key(), 3'($urandom), 3'($urandom));
	endfunction

	task automatic drain();
		wait (pending_q.size() == 0 && !req_ch.valid && expected_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_fill(logic [11:0] v);
		drain();
		@(posedge clk);
		max_fill_we <= 1'b1;
		max_fill_wdata <= v;
		@(posedge clk);
		max_fill_we <= 1'b0;
		fill_limit = v;
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 80 == 0) begin
				calm_tx = ($urandom_range(0, 3) == 0);
				calm_rx = ($urandom_range(0, 3) == 0);
			end
			pending_q.push_back(random_item());
		end
	endtask

	initial begin
		for (int i = 0; i < TBL; i++)
			occ_tab[i] = 0;
		hot_key = rand_key();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		pending_q.push_back(mk(KIND_PUT, 64'd0, 3'd0, 3'd7));
		pending_q.push_back(mk(KIND_PUT, '1, 3'd4, 3'd3));
		pending_q.push_back(mk(KIND_PUT, 64'd0, 3'd1, 3'd2));
		pending_q.push_back(mk(KIND_PUT, 64'd0, 3'd2, 3'd1));
		pending_q.push_back(mk(KIND_PUT, 64'd0, 3'd3, 3'd0));
		pending_q.push_back(mk(KIND_PUT, 64'd0, 3'd5, 3'd6));
		pending_q.push_back(mk(KIND_SEARCH, 64'd0, 3'd0, 3'd0));
		pending_q.push_back(mk(KIND_SEARCH, '1, 3'd7, 3'd7));
		pending_q.push_back(mk(KIND_SEARCH, 64'd12345, 3'd0, 3'd0));
		pending_q.push_back(mk(KIND_PUT, 64'd77, 3'd0, 3'd0));
		pending_q.push_back(mk(KIND_PUT, 64'd77 + 64'(TBL), 3'd1, 3'd1));
		pending_q.push_back(mk(KIND_PUT, 64'd77 + 64'(2 * TBL), 3'd2, 3'd2));
		pending_q.push_back(mk(KIND_SEARCH, 64'd77 + 64'(TBL), 3'd0, 3'd0));
		pending_q.push_back(mk(KIND_SEARCH, 64'd77 + 64'(3 * TBL), 3'd0, 3'd0));
		pending_q.push_back(mk(KIND_PUT, 64'(TBL - 1), 3'd3, 3'd3));
		pending_q.push_back(mk(KIND_PUT, 64'(2 * TBL - 1), 3'd3, 3'd3));
		pending_q.push_back(mk(KIND_SEARCH, 64'(2 * TBL - 1), 3'd0, 3'd0));
		known_keys.push_back(64'd0);
		known_keys.push_back('1);
		known_keys.push_back(64'd77 + 64'(TBL));

		write_fill(12'd0);
		pending_q.push_back(mk(KIND_PUT, 64'd999, 3'd0, 3'd0));
		pending_q.push_back(mk(KIND_PUT, 64'd77, 3'd0, 3'd3));
		pending_q.push_back(mk(KIND_SEARCH, 64'd999, 3'd0, 3'd0));
		pending_q.push_back(mk(KIND_PUT, 64'(2 * TBL - 1), 3'd1, 3'd4));

		write_fill(12'd4093);
		run_random(540);
		drain();
		write_fill(12'(stored_cnt + 20));
		run_random(480);
		write_fill(MAX_FILL_RST);
		run_random(500);
		drain();

		calm_tx = 0;
		calm_rx = 0;
		for (int i = 0; i < 3; i++) begin
			pending_q.push_back(mk(KIND_SEARCH, rand_key(), 3'd0, 3'd0));
			pending_q.push_back(mk(KIND_PUT, rand_key(), 3'($urandom), 3'($urandom)));
			pending_q.push_back(mk(KIND_PUT, known_keys[$urandom_range(0, known_keys.size() - 1)],
				3'($urandom), 3'($urandom)));
		end
		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#200000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
src/kmer_pkg.sv
src/kmer_if.sv
src/kmer_front.sv
src/kmer_queue.sv
src/kmer_back.sv
src/kmer_count_hash_table.sv
test/tb_kmer_count_hash_table.sv
